// File: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/hng_pkg.sv
// shared types, constants and the vertex sum function of the normal generator
package hng_pkg;

    localparam int HEIGHT_W   = 24;
    localparam int SUM_W      = 27;
    localparam int MAG_W      = 26;
    localparam int CNT_W      = 3;
    localparam int IDX_W      = 11;
    localparam int NXZ_W      = 16;
    localparam int NY_W       = 15;
    localparam int ROOT_W     = 86;
    localparam int ROOT_K_W   = 4;
    localparam int ROOT_M_W   = 16;
    localparam int ROOT_SHIFT = 30;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = 2;
    localparam logic [IDX_W-1:0] GRID_SIDE_RESET = 11'd257;

    typedef struct packed {
        logic signed [SUM_W-1:0] sx;
        logic signed [SUM_W-1:0] sz;
        logic [CNT_W-1:0]        cnt;
    } sum_t;

    typedef struct packed {
        sum_t             vec;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] row;
        logic             done;
    } req_t;

    // sum of the in-grid quad cross products around one vertex
    function automatic sum_t vertex_sum(
        input logic signed [HEIGHT_W-1:0] h,
        input logic hs, input logic signed [HEIGHT_W-1:0] vs,
        input logic he, input logic signed [HEIGHT_W-1:0] ve,
        input logic hn, input logic signed [HEIGHT_W-1:0] vn,
        input logic hw, input logic signed [HEIGHT_W-1:0] vw
    );
        logic signed [HEIGHT_W:0] a, b, c, d;
        sum_t res;
        a = (HEIGHT_W+1)'(h) - (HEIGHT_W+1)'(vs);
        b = (HEIGHT_W+1)'(h) - (HEIGHT_W+1)'(ve);
        c = (HEIGHT_W+1)'(h) - (HEIGHT_W+1)'(vn);
        d = (HEIGHT_W+1)'(h) - (HEIGHT_W+1)'(vw);
        res.sx  = '0;
        res.sz  = '0;
        res.cnt = '0;
        if (he && hs) begin
            res.sx  = res.sx + SUM_W'(b);
            res.sz  = res.sz + SUM_W'(a);
            res.cnt = res.cnt + 3'd1;
        end
        if (he && hn) begin
            res.sx  = res.sx + SUM_W'(b);
            res.sz  = res.sz - SUM_W'(c);
            res.cnt = res.cnt + 3'd1;
        end
        if (hw && hn) begin
            res.sx  = res.sx - SUM_W'(d);
            res.sz  = res.sz - SUM_W'(c);
            res.cnt = res.cnt + 3'd1;
        end
        if (hw && hs) begin
            res.sx  = res.sx - SUM_W'(d);
            res.sz  = res.sz + SUM_W'(a);
            res.cnt = res.cnt + 3'd1;
        end
        return res;
    endfunction

endpackage

// File: rtl/hng_front.sv
// front end: row stores, counters and building of up to three normal requests per item
module hng_front #(
    parameter int MAX_SIDE = 1025
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [hng_pkg::IDX_W-1:0]            cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [hng_pkg::HEIGHT_W-1:0]  s_height,
    output logic                                 q_push,
    output hng_pkg::req_t                        q_data,
    input  logic                                 q_full
);

    localparam int AW = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
    localparam int SIDE_CAP = (MAX_SIDE > 2047) ? 2047 : MAX_SIDE;
    localparam logic [hng_pkg::IDX_W-1:0] SIDE_MAX = hng_pkg::IDX_W'(SIDE_CAP);
    localparam logic [hng_pkg::IDX_W-1:0] SIDE_MIN = 11'd2;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD2  = 2'd1;
    localparam logic [1:0] ST_CALC = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] state_reg, state_next;

    logic [hng_pkg::IDX_W-1:0] side_reg;
    logic [hng_pkg::IDX_W-1:0] col_reg, row_reg;
    logic [hng_pkg::IDX_W-1:0] x_reg, r_reg;
    logic signed [hng_pkg::HEIGHT_W-1:0] h_reg, prev1_reg, prev2_reg;
    logic signed [hng_pkg::HEIGHT_W-1:0] nw_x_reg, od_x_reg;
    logic signed [hng_pkg::HEIGHT_W-1:0] rd_new_reg, rd_old_reg;
    hng_pkg::req_t req_reg [3];
    logic [2:0] pend_reg, pend_next;

    logic signed [hng_pkg::HEIGHT_W-1:0] newer_mem [MAX_SIDE];
    logic signed [hng_pkg::HEIGHT_W-1:0] older_mem [MAX_SIDE];

    logic [hng_pkg::IDX_W-1:0] side_eff, last, cur_x, cur_y;
    logic [AW-1:0] new_ra, old_ra, wa;
    logic mem_we, accept;
    hng_pkg::sum_t sum1, sum2, sum3;
    logic [2:0] pend_calc;
    logic [2:0] sel;

    always_comb begin
        if (side_reg < SIDE_MIN) begin
            side_eff = SIDE_MIN;
        end else if (side_reg > SIDE_MAX) begin
            side_eff = SIDE_MAX;
        end else begin
            side_eff = side_reg;
        end
    end

    assign last    = side_eff - 11'd1;
    assign cur_x   = (col_reg >= side_eff) ? '0 : col_reg;
    assign cur_y   = (row_reg >= side_eff) ? '0 : row_reg;
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // first read at accept, neighbor read in the next cycle (ST_RD2)
    always_comb begin
        if (state_reg == ST_IDLE) begin
            new_ra = AW'(cur_x);
            old_ra = AW'(cur_x);
        end else begin
            new_ra = (x_reg == last) ? AW'(x_reg) : AW'(x_reg + 11'd1);
            old_ra = (x_reg == '0) ? AW'(x_reg) : AW'(x_reg - 11'd1);
        end
    end

    assign mem_we = (state_reg == ST_CALC);
    assign wa     = AW'(x_reg);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            newer_mem[wa] <= h_reg;
            older_mem[wa] <= nw_x_reg;
        end
        rd_new_reg <= newer_mem[new_ra];
        rd_old_reg <= older_mem[old_ra];
    end

    always_comb begin
        sum1 = hng_pkg::vertex_sum(nw_x_reg, 1'b1, h_reg,
                                   x_reg < last, rd_new_reg,
                                   r_reg >= 11'd2, od_x_reg,
                                   x_reg > '0, rd_old_reg);
        sum2 = hng_pkg::vertex_sum(prev1_reg, 1'b0, '0,
                                   1'b1, h_reg,
                                   1'b1, rd_old_reg,
                                   x_reg >= 11'd2, prev2_reg);
        sum3 = hng_pkg::vertex_sum(h_reg, 1'b0, '0,
                                   1'b0, '0,
                                   1'b1, nw_x_reg,
                                   1'b1, prev1_reg);
        pend_calc = {(r_reg == last) && (x_reg == last),
                     (r_reg == last) && (x_reg >= 11'd1),
                     r_reg >= 11'd1};
    end

    // lowest pending request goes first
    always_comb begin
        priority if (pend_reg[0]) begin
            sel = 3'b001;
        end else if (pend_reg[1]) begin
            sel = 3'b010;
        end else begin
            sel = {pend_reg[2], 2'b00};
        end
    end

    always_comb begin
        unique case (sel)
            3'b001:  q_data = req_reg[0];
            3'b010:  q_data = req_reg[1];
            default: q_data = req_reg[2];
        endcase
    end

    assign q_push = (state_reg == ST_EMIT) && !q_full && (pend_reg != '0);

    always_comb begin
        state_next = state_reg;
        pend_next  = pend_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_RD2;
                end
            end
            ST_RD2: begin
                state_next = ST_CALC;
            end
            ST_CALC: begin
                pend_next  = pend_calc;
                state_next = (pend_calc == '0) ? ST_IDLE : ST_EMIT;
            end
            default: begin
                if (q_push) begin
                    pend_next  = pend_reg & ~sel;
                    state_next = ((pend_reg & ~sel) == '0) ? ST_IDLE : ST_EMIT;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg <= cur_x;
            r_reg <= cur_y;
            h_reg <= s_height;
        end
        if (state_reg == ST_RD2) begin
            nw_x_reg <= rd_new_reg;
            od_x_reg <= rd_old_reg;
        end
        if (state_reg == ST_CALC) begin
            req_reg[0] <= '{vec: sum1, col: x_reg, row: r_reg - 11'd1, done: 1'b0};
            req_reg[1] <= '{vec: sum2, col: x_reg - 11'd1, row: r_reg, done: 1'b0};
            req_reg[2] <= '{vec: sum3, col: x_reg, row: r_reg, done: 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pend_reg  <= '0;
            side_reg  <= hng_pkg::GRID_SIDE_RESET;
            col_reg   <= '0;
            row_reg   <= '0;
            prev1_reg <= '0;
            prev2_reg <= '0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            if (state_reg == ST_CALC) begin
                prev2_reg <= prev1_reg;
                prev1_reg <= h_reg;
                if (x_reg == last) begin
                    col_reg <= '0;
                    row_reg <= (r_reg == last) ? '0 : r_reg + 11'd1;
                end else begin
                    col_reg <= x_reg + 11'd1;
                    row_reg <= r_reg;
                end
            end
            if (cfg_wr_en) begin
                side_reg <= cfg_wr_data;
                col_reg  <= '0;
                row_reg  <= '0;
            end
        end
    end

endmodule

// File: rtl/hng_queue.sv
// small request fifo between the front end and the normalizer
module hng_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  hng_pkg::req_t push_data,
    output logic          full,
    input  logic          pop,
    output hng_pkg::req_t pop_data,
    output logic          empty
);

    hng_pkg::req_t mem_reg [hng_pkg::Q_DEPTH];
    logic [hng_pkg::Q_PTR_W-1:0] wp_reg, rp_reg;
    logic [hng_pkg::Q_PTR_W:0]   cnt_reg;
    logic do_push, do_pop;

    assign full     = (cnt_reg == (hng_pkg::Q_PTR_W+1)'(hng_pkg::Q_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (do_pop) begin
                rp_reg <= rp_reg + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

// File: rtl/hng_norm.sv
// back end: squares, bit-serial unit scaling of three lanes, result register
module hng_norm (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               q_empty,
    input  hng_pkg::req_t                      q_data,
    output logic                               q_pop,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [hng_pkg::NXZ_W-1:0]   m_normal_x,
    output logic [hng_pkg::NY_W-1:0]           m_normal_y,
    output logic signed [hng_pkg::NXZ_W-1:0]   m_normal_z,
    output logic [hng_pkg::IDX_W-1:0]          m_column,
    output logic [hng_pkg::IDX_W-1:0]          m_row,
    output logic                               m_grid_done
);

    localparam int SQ_W = 2 * hng_pkg::MAG_W;
    localparam int S_W  = SQ_W + 2;

    localparam logic [2:0] NS_IDLE = 3'd0;
    localparam logic [2:0] NS_SQ   = 3'd1;
    localparam logic [2:0] NS_SUM  = 3'd2;
    localparam logic [2:0] NS_ITER = 3'd3;
    localparam logic [2:0] NS_OUT  = 3'd4;

    logic [2:0] state_reg, state_next;

    logic [hng_pkg::MAG_W-1:0] mag_reg [3];
    logic [SQ_W-1:0]           sq_reg  [3];
    logic [hng_pkg::ROOT_W-1:0] rem_reg [3];
    logic [hng_pkg::ROOT_W-1:0] t1_reg  [3];
    logic [hng_pkg::ROOT_M_W-1:0] m_reg [3];
    logic [hng_pkg::ROOT_W-1:0] t2_reg;
    logic [hng_pkg::ROOT_K_W-1:0] k_reg;
    logic neg_x_reg, neg_z_reg;
    logic [hng_pkg::IDX_W-1:0] col_reg, row_reg;
    logic done_reg;

    logic [hng_pkg::ROOT_W-1:0] rem_next [3];
    logic [hng_pkg::ROOT_W-1:0] t1_next  [3];
    logic [hng_pkg::ROOT_M_W-1:0] m_next [3];
    logic [hng_pkg::ROOT_W-1:0] trial;
    logic [hng_pkg::ROOT_M_W-1:0] bit_k;
    logic [S_W-1:0] s_sum;
    logic [hng_pkg::ROOT_M_W:0] rnd [3];
    logic [hng_pkg::NY_W-1:0] q [3];
    logic load_out;

    logic m_valid_reg;
    logic signed [hng_pkg::NXZ_W-1:0] nx_reg, nz_reg;
    logic [hng_pkg::NY_W-1:0] ny_reg;
    logic [hng_pkg::IDX_W-1:0] ocol_reg, orow_reg;
    logic odone_reg;

    assign q_pop = (state_reg == NS_IDLE) && !q_empty;
    assign bit_k = hng_pkg::ROOT_M_W'(1) << k_reg;
    assign s_sum = S_W'(sq_reg[0]) + S_W'(sq_reg[1]) + S_W'(sq_reg[2]);

    // one trial subtract per lane and step
    always_comb begin
        trial = '0;
        for (int i = 0; i < 3; i++) begin
            trial       = t1_reg[i] + t2_reg;
            rem_next[i] = rem_reg[i];
            t1_next[i]  = t1_reg[i];
            m_next[i]   = m_reg[i];
            if (trial <= rem_reg[i]) begin
                rem_next[i] = rem_reg[i] - trial;
                t1_next[i]  = t1_reg[i] + (t2_reg << 1);
                m_next[i]   = m_reg[i] | bit_k;
            end
        end
    end

    // nearest integer from the doubled floor root
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rnd[i] = {1'b0, m_reg[i]} + (hng_pkg::ROOT_M_W+1)'(1);
            q[i]   = rnd[i][hng_pkg::NY_W:1];
        end
    end

    assign load_out = (state_reg == NS_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            NS_IDLE: if (q_pop) state_next = NS_SQ;
            NS_SQ:   state_next = NS_SUM;
            NS_SUM:  state_next = NS_ITER;
            NS_ITER: if (k_reg == '0) state_next = NS_OUT;
            NS_OUT:  if (load_out) state_next = NS_IDLE;
            default: state_next = NS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            mag_reg[0] <= q_data.vec.sx[hng_pkg::SUM_W-1] ?
                          hng_pkg::MAG_W'(-q_data.vec.sx) : hng_pkg::MAG_W'(q_data.vec.sx);
            mag_reg[1] <= hng_pkg::MAG_W'({q_data.vec.cnt, 8'd0});
            mag_reg[2] <= q_data.vec.sz[hng_pkg::SUM_W-1] ?
                          hng_pkg::MAG_W'(-q_data.vec.sz) : hng_pkg::MAG_W'(q_data.vec.sz);
            neg_x_reg  <= q_data.vec.sx[hng_pkg::SUM_W-1];
            neg_z_reg  <= q_data.vec.sz[hng_pkg::SUM_W-1];
            col_reg    <= q_data.col;
            row_reg    <= q_data.row;
            done_reg   <= q_data.done;
        end
        if (state_reg == NS_SQ) begin
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= SQ_W'(mag_reg[i]) * SQ_W'(mag_reg[i]);
            end
        end
        if (state_reg == NS_SUM) begin
            t2_reg <= hng_pkg::ROOT_W'(s_sum) << hng_pkg::ROOT_SHIFT;
            k_reg  <= hng_pkg::ROOT_K_W'(hng_pkg::ROOT_M_W - 1);
            for (int i = 0; i < 3; i++) begin
                rem_reg[i] <= hng_pkg::ROOT_W'(sq_reg[i]) << hng_pkg::ROOT_SHIFT;
                t1_reg[i]  <= '0;
                m_reg[i]   <= '0;
            end
        end
        if (state_reg == NS_ITER) begin
            t2_reg <= t2_reg >> 2;
            k_reg  <= k_reg - 1'b1;
            for (int i = 0; i < 3; i++) begin
                rem_reg[i] <= rem_next[i];
                t1_reg[i]  <= t1_next[i] >> 1;
                m_reg[i]   <= m_next[i];
            end
        end
        if (load_out) begin
            nx_reg    <= neg_x_reg ? -hng_pkg::NXZ_W'(q[0]) : hng_pkg::NXZ_W'(q[0]);
            ny_reg    <= q[1];
            nz_reg    <= neg_z_reg ? -hng_pkg::NXZ_W'(q[2]) : hng_pkg::NXZ_W'(q[2]);
            ocol_reg  <= col_reg;
            orow_reg  <= row_reg;
            odone_reg <= done_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= NS_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_normal_x  = nx_reg;
    assign m_normal_y  = ny_reg;
    assign m_normal_z  = nz_reg;
    assign m_column    = ocol_reg;
    assign m_row       = orow_reg;
    assign m_grid_done = odone_reg;

endmodule

// File: rtl/heightmap_normal_generator_top.sv
// top level of the streaming height map vertex normal generator
// order: a taken item passes the front end states, then its normals enter the queue;
//   in the normalizer each normal passes pop, square, sum, 16 root steps and a result load
// throughput: front end takes no item until its normals are pushed; the normalizer pops
//   no normal until the last is loaded, and its shared 16-step root loop sets the rate
// reset: synchronous active-low aresetn clears counters, row window, grid_side (to 257),
//   queue and valid flags; the row stores are not cleared and hold no valid bits
module heightmap_normal_generator_top #(
    parameter int MAX_SIDE = 1025
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // grid side register
    input  logic                               cfg_wr_en,
    input  logic [hng_pkg::IDX_W-1:0]          cfg_wr_data,
    // height items in raster order
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [hng_pkg::HEIGHT_W-1:0] s_height,
    // normal items
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [hng_pkg::NXZ_W-1:0]   m_normal_x,
    output logic [hng_pkg::NY_W-1:0]           m_normal_y,
    output logic signed [hng_pkg::NXZ_W-1:0]   m_normal_z,
    output logic [hng_pkg::IDX_W-1:0]          m_column,
    output logic [hng_pkg::IDX_W-1:0]          m_row,
    output logic                               m_grid_done
);

    // request path from the front end into the fifo
    logic          q_push;
    logic          q_full;
    hng_pkg::req_t q_in;

    // request path from the fifo into the normalizer
    logic          q_pop;
    logic          q_empty;
    hng_pkg::req_t q_out;

    // front end: counters, two row stores, and the cross product sums
    hng_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_height    (s_height),
        .q_push      (q_push),
        .q_data      (q_in),
        .q_full      (q_full)
    );

    // decouples the front end from the slow normalizer
    hng_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    // unit-length scaling with rounding to nearest, then the result register
    hng_norm u_norm (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_empty     (q_empty),
        .q_data      (q_out),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_normal_x  (m_normal_x),
        .m_normal_y  (m_normal_y),
        .m_normal_z  (m_normal_z),
        .m_column    (m_column),
        .m_row       (m_row),
        .m_grid_done (m_grid_done)
    );

endmodule

// File: rtl/hng_checker.sv
// port-level checker for the normal generator and its bind
`include "assert_macros.svh"

module hng_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [hng_pkg::NXZ_W-1:0]   m_normal_x,
    input logic [hng_pkg::NY_W-1:0]           m_normal_y,
    input logic [hng_pkg::IDX_W-1:0]          m_column,
    input logic [hng_pkg::IDX_W-1:0]          m_row,
    input logic                               m_grid_done
);

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_normal_x), "normal item dropped or changed while stalled")
    `ASSERT_IMPL(a_y_range, aclk, aresetn, m_valid, m_normal_y <= 15'd16384, "normal y component beyond unit length")
    `ASSERT_IMPL(a_x_range, aclk, aresetn, m_valid, (m_normal_x <= 16'sd16384) && (m_normal_x >= -16'sd16384), "normal x component beyond unit length")
    `ASSERT_IMPL(a_done_corner, aclk, aresetn, m_valid && m_grid_done, m_column == m_row, "grid done flag off the last corner")

endmodule

bind heightmap_normal_generator_top hng_checker u_hng_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_normal_x  (m_normal_x),
    .m_normal_y  (m_normal_y),
    .m_column    (m_column),
    .m_row       (m_row),
    .m_grid_done (m_grid_done)
);

// File: tb/sv/testbench.sv
// self-checking testbench for the height map vertex normal generator
`timescale 1ns / 100ps

module testbench;

    localparam int GRID_MAX      = 1025;
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int SETTLE_CYCLES = 100;
    localparam logic [hng_pkg::NY_W-1:0] UNIT_ONE = 15'd16384;

    typedef struct {
        logic signed [hng_pkg::NXZ_W-1:0] nx;
        logic [hng_pkg::NY_W-1:0]         ny;
        logic signed [hng_pkg::NXZ_W-1:0] nz;
        logic [hng_pkg::IDX_W-1:0]        col;
        logic [hng_pkg::IDX_W-1:0]        row;
        logic                             done;
    } normal_t;

    // one directed entry: height, and whether its normals are flat by inspection
    typedef struct {
        logic signed [hng_pkg::HEIGHT_W-1:0] height;
        logic                                flat;
    } stim_row_t;

    logic aclk;
    logic aresetn;
    logic cfg_wr_en;
    logic [hng_pkg::IDX_W-1:0] cfg_wr_data;
    logic s_valid;
    logic s_ready;
    logic signed [hng_pkg::HEIGHT_W-1:0] s_height;
    logic m_valid;
    logic m_ready;
    logic signed [hng_pkg::NXZ_W-1:0] m_normal_x;
    logic [hng_pkg::NY_W-1:0] m_normal_y;
    logic signed [hng_pkg::NXZ_W-1:0] m_normal_z;
    logic [hng_pkg::IDX_W-1:0] m_column;
    logic [hng_pkg::IDX_W-1:0] m_row;
    logic m_grid_done;

    heightmap_normal_generator_top #(.MAX_SIDE(GRID_MAX)) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_height    (s_height),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_normal_x  (m_normal_x),
        .m_normal_y  (m_normal_y),
        .m_normal_z  (m_normal_z),
        .m_column    (m_column),
        .m_row       (m_row),
        .m_grid_done (m_grid_done)
    );

    // mirror of the block state
    logic signed [hng_pkg::HEIGHT_W-1:0] older_row [GRID_MAX];
    logic signed [hng_pkg::HEIGHT_W-1:0] newer_row [GRID_MAX];
    logic signed [hng_pkg::HEIGHT_W-1:0] row_win [3];
    int unsigned mir_col;
    int unsigned mir_row;
    logic [hng_pkg::IDX_W-1:0] mir_side;

    normal_t expected_normals[$];
    logic signed [hng_pkg::HEIGHT_W-1:0] height_fifo[$];
    logic flat_fifo[$];
    int errors;
    int unsigned cycle_count;

    // round(16384 * mag / sqrt(s)), ties up, by bisection on squares
    function automatic int unsigned unit_mag(longint unsigned mag, longint unsigned s);
        logic [127:0] rhs;
        logic [127:0] lhs;
        logic [127:0] k;
        int unsigned lo;
        int unsigned hi;
        int unsigned q;
        rhs = 128'(mag) * 128'(mag);
        rhs = rhs << 30;
        lo = 0;
        hi = 16384;
        while (lo < hi) begin
            q = (lo + hi + 1) / 2;
            k = 128'(2 * q - 1);
            lhs = k * k * 128'(s);
            if (lhs <= rhs) lo = q;
            else hi = q - 1;
        end
        return lo;
    endfunction

    function automatic int signed_unit(longint v, longint unsigned s);
        int unsigned m;
        m = unit_mag(v < 0 ? longint'(-v) : longint'(v), s);
        return v < 0 ? -int'(m) : int'(m);
    endfunction

    // in-grid cross product sum, normalized, queued as expected
    task automatic push_normal(
        input longint h,
        input bit hs, input longint vs, input bit he, input longint ve,
        input bit hn, input longint vn, input bit hw, input longint vw,
        input int unsigned col, input int unsigned row, input bit done, input bit flat
    );
        longint a, b, c, d, sx, sy, sz;
        longint unsigned s;
        normal_t n;
        a = h - vs; b = h - ve; c = h - vn; d = h - vw;
        sx = 0; sy = 0; sz = 0;
        if (he && hs) begin sx += b; sy += 256; sz += a; end
        if (he && hn) begin sx += b; sy += 256; sz -= c; end
        if (hw && hn) begin sx -= d; sy += 256; sz -= c; end
        if (hw && hs) begin sx -= d; sy += 256; sz += a; end
        s = longint'(sx * sx) + longint'(sy * sy) + longint'(sz * sz);
        n.nx = hng_pkg::NXZ_W'(signed_unit(sx, s));
        n.ny = hng_pkg::NY_W'(signed_unit(sy, s));
        n.nz = hng_pkg::NXZ_W'(signed_unit(sz, s));
        n.col = hng_pkg::IDX_W'(col);
        n.row = hng_pkg::IDX_W'(row);
        n.done = done;
        // flat neighborhood: straight up, typed in
        if (flat) begin
            n.nx = '0;
            n.ny = UNIT_ONE;
            n.nz = '0;
        end
        expected_normals.push_back(n);
    endtask

    // advance the mirror by one accepted height
    task automatic predict_height(input logic signed [hng_pkg::HEIGHT_W-1:0] hv,
                                  input bit flat);
        int unsigned side;
        int unsigned x;
        int unsigned r;
        side = mir_side < 2 ? 2 : (mir_side > GRID_MAX ? GRID_MAX : mir_side);
        if (mir_col >= side) mir_col = 0;
        if (mir_row >= side) mir_row = 0;
        x = mir_col;
        r = mir_row;
        row_win[0] = row_win[1];
        row_win[1] = row_win[2];
        row_win[2] = hv;
        if (r >= 1)
            push_normal(newer_row[x], 1, hv,
                        x + 1 < side, x + 1 < side ? newer_row[x + 1] : 0,
                        r >= 2, r >= 2 ? older_row[x] : 0,
                        x > 0, x > 0 ? older_row[x - 1] : 0,
                        x, r - 1, 0, flat);
        if (r == side - 1) begin
            if (x >= 1)
                push_normal(row_win[1], 0, 0, 1, hv, 1, older_row[x - 1],
                            x >= 2, x >= 2 ? row_win[0] : 0, x - 1, r, 0, flat);
            if (x == side - 1)
                push_normal(hv, 0, 0, 0, 0, 1, newer_row[x], 1, row_win[1], x, r, 1, flat);
        end
        older_row[x] = newer_row[x];
        newer_row[x] = hv;
        x++;
        if (x >= side) begin
            x = 0;
            r++;
            if (r >= side) r = 0;
        end
        mir_col = x;
        mir_row = r;
    endtask

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // sender: bursts of random length with random gaps
    int burst_left;
    int gap_left;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            if (s_valid && s_ready) predict_height(s_height, flat_fifo.pop_front());
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (height_fifo.size() > 0) begin
                    s_valid <= 1'b1;
                    s_height <= height_fifo.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        // long stretches without gaps now and then
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern of its own, plus the result check
    int stall_mode;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_mode <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_normals.size() == 0) begin
                    $error("normal item with nothing expected: col %0d row %0d",
                           m_column, m_row);
                    errors++;
                end else begin
                    normal_t e;
                    e = expected_normals.pop_front();
                    if (m_normal_x !== e.nx) begin
                        $error("normal_x expected %0d actual %0d", e.nx, m_normal_x);
                        errors++;
                    end
                    if (m_normal_y !== e.ny) begin
                        $error("normal_y expected %0d actual %0d", e.ny, m_normal_y);
                        errors++;
                    end
                    if (m_normal_z !== e.nz) begin
                        $error("normal_z expected %0d actual %0d", e.nz, m_normal_z);
                        errors++;
                    end
                    if (m_column !== e.col) begin
                        $error("column expected %0d actual %0d", e.col, m_column);
                        errors++;
                    end
                    if (m_row !== e.row) begin
                        $error("row expected %0d actual %0d", e.row, m_row);
                        errors++;
                    end
                    if (m_grid_done !== e.done) begin
                        $error("grid_done expected %0d actual %0d", e.done, m_grid_done);
                        errors++;
                    end
                end
            end
            if ($urandom_range(0, 200) == 0) stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: begin
                    m_ready <= 1'b1;
                end
                1: begin
                    m_ready <= $urandom_range(0, 1);
                end
                default: begin
                    m_ready <= ($urandom_range(0, 7) == 0);
                end
            endcase
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("heightmap_normal_generator_top: mismatch");
            $finish;
        end
    end

    // wait until every item is taken and every normal has come, then let it settle
    task automatic wait_drained();
        while (height_fifo.size() > 0 || s_valid || expected_normals.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_side(input logic [hng_pkg::IDX_W-1:0] v);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        mir_side = v;
        mir_col = 0;
        mir_row = 0;
    endtask

    // random height: smooth terrain mostly, with full range noise and extremes
    function automatic logic signed [hng_pkg::HEIGHT_W-1:0] rand_height(input int base);
        case ($urandom_range(0, 9))
            0: return hng_pkg::HEIGHT_W'($urandom);
            1: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
            default: return hng_pkg::HEIGHT_W'(base + int'($urandom_range(0, 2047)) - 1024);
        endcase
    endfunction

    task automatic send_grid(input int count);
        int base;
        base = int'($urandom_range(0, 16777215)) - 8388608;
        for (int i = 0; i < count; i++) begin
            height_fifo.push_back(rand_height(base));
            flat_fifo.push_back(1'b0);
        end
    endtask

    stim_row_t directed[] = '{
        // flat 2x2 grid at zero
        '{24'sh000000, 1'b1}, '{24'sh000000, 1'b1}, '{24'sh000000, 1'b1},
        '{24'sh000000, 1'b1},
        // 2x2 checkerboard of extremes
        '{24'sh7fffff, 1'b0}, '{24'sh800000, 1'b0}, '{24'sh800000, 1'b0},
        '{24'sh7fffff, 1'b0},
        // 3x3 with extremes around a zero center
        '{24'sh800000, 1'b0}, '{24'sh7fffff, 1'b0}, '{24'sh800000, 1'b0},
        '{24'sh7fffff, 1'b0}, '{24'sh000000, 1'b0}, '{24'sh7fffff, 1'b0},
        '{24'sh800000, 1'b0}, '{24'sh7fffff, 1'b0}, '{24'sh800000, 1'b0},
        // flat 2x2 grid at the top height
        '{24'sh7fffff, 1'b1}, '{24'sh7fffff, 1'b1}, '{24'sh7fffff, 1'b1},
        '{24'sh7fffff, 1'b1}
    };
    logic [hng_pkg::IDX_W-1:0] directed_side[] = '{11'd0, 11'd2, 11'd3, 11'd1};
    int directed_len[] = '{4, 4, 9, 4};
    int unsigned small_sides[] = '{2, 3, 4, 5, 6, 7, 8, 9, 16};

    initial begin
        int pos;
        int budget;
        int side;
        errors = 0;
        cycle_count = 0;
        mir_side = hng_pkg::GRID_SIDE_RESET;
        mir_col = 0;
        mir_row = 0;
        for (int i = 0; i < 3; i++) row_win[i] = '0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_height = '0;
        m_ready = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // reset side: first row and part of the second
        send_grid(260);

        // directed grids
        pos = 0;
        for (int g = 0; g < directed_side.size(); g++) begin
            write_side(directed_side[g]);
            for (int i = 0; i < directed_len[g]; i++) begin
                height_fifo.push_back(directed[pos].height);
                flat_fifo.push_back(directed[pos].flat);
                pos++;
            end
        end

        // random whole grids of small sides
        budget = 50;
        while (budget > 0) begin
            side = small_sides[$urandom_range(0, small_sides.size() - 1)];
            write_side(hng_pkg::IDX_W'(side));
            send_grid(side * side);
            budget -= side * side;
        end

        // widest grids: part of a first row each, cut short by the next write, then a whole grid of side 4
        write_side(11'd2047);
        send_grid(10);
        write_side(11'd1025);
        send_grid(5);
        write_side(11'd4);
        send_grid(16);

        wait_drained();
        if (errors == 0)
            $display("heightmap_normal_generator_top: match");
        else
            $display("heightmap_normal_generator_top: mismatch");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/hng_pkg.sv
rtl/hng_front.sv
rtl/hng_queue.sv
rtl/hng_norm.sv
rtl/heightmap_normal_generator_top.sv
rtl/hng_checker.sv
tb/sv/testbench.sv
